[rtl/core/e2r_pkg.sv]
// ----------------------------------------------------------------------------
// e2r_pkg
// Shared types, constants and rounding helpers for the Euler-to-rotation block.
// ----------------------------------------------------------------------------
package e2r_pkg;

	localparam int ANGLE_FRACTION_BITS_DEF = 7;
	localparam int ENTRY_FRACTION_BITS_DEF = 14;

	localparam int ANGLE_W = 16;
	localparam int ENTRY_W = 16;
	localparam int Q_W     = 32;   // signed Q30 with room for +1.0
	localparam int PROD_W  = 64;
	localparam int SUM_W   = 66;

	localparam logic signed [Q_W-1:0] Q30_ONE = 32'sd1 << 30;
	localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;

	// rotation order codes
	localparam logic [1:0] ORD_XYZ     = 2'd0;
	localparam logic [1:0] ORD_ZYX     = 2'd1;
	localparam logic [1:0] ORDER_RESET = 2'd3;

	// pipeline depths
	localparam int LANE_DEPTH = 18;
	localparam int MM_DEPTH   = 2;
	localparam int PIPE_DEPTH = LANE_DEPTH + 2 * MM_DEPTH;

	typedef logic signed [Q_W-1:0] q30_t;
	typedef q30_t mat_t [3][3];

	typedef struct packed {
		logic signed [ENTRY_W-1:0] e00;
		logic signed [ENTRY_W-1:0] e01;
		logic signed [ENTRY_W-1:0] e02;
		logic signed [ENTRY_W-1:0] e10;
		logic signed [ENTRY_W-1:0] e11;
		logic signed [ENTRY_W-1:0] e12;
		logic signed [ENTRY_W-1:0] e20;
		logic signed [ENTRY_W-1:0] e21;
		logic signed [ENTRY_W-1:0] e22;
		logic                      err;
	} res_t;

	// round to nearest, half away from zero, dropping n fraction bits
	function automatic logic signed [SUM_W-1:0] round_shift(
		input logic signed [SUM_W-1:0] v, input int unsigned n);
		logic [SUM_W-1:0] half;
		logic [SUM_W-1:0] mag;
		logic [SUM_W-1:0] res;
		half = (SUM_W'(1) << n) >> 1;
		mag  = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
		res  = (mag + half) >> n;
		return v[SUM_W-1] ? -$signed(res) : $signed(res);
	endfunction

	function automatic mat_t rot_x(input q30_t s, input q30_t c);
		mat_t m;
		m[0][0] = Q30_ONE; m[0][1] = '0;  m[0][2] = '0;
		m[1][0] = '0;      m[1][1] = c;   m[1][2] = -s;
		m[2][0] = '0;      m[2][1] = s;   m[2][2] = c;
		return m;
	endfunction

	function automatic mat_t rot_y(input q30_t s, input q30_t c);
		mat_t m;
		m[0][0] = c;  m[0][1] = '0;      m[0][2] = s;
		m[1][0] = '0; m[1][1] = Q30_ONE; m[1][2] = '0;
		m[2][0] = -s; m[2][1] = '0;      m[2][2] = c;
		return m;
	endfunction

	function automatic mat_t rot_z(input q30_t s, input q30_t c);
		mat_t m;
		m[0][0] = c;  m[0][1] = -s; m[0][2] = '0;
		m[1][0] = s;  m[1][1] = c;  m[1][2] = '0;
		m[2][0] = '0; m[2][1] = '0; m[2][2] = Q30_ONE;
		return m;
	endfunction

endpackage

[rtl/core/e2r_sincos.sv]
// ----------------------------------------------------------------------------
// e2r_sincos
// One angle lane: quadrant fold, degrees to radians, Taylor sine/cosine.
// ----------------------------------------------------------------------------
module e2r_sincos import e2r_pkg::*; #(
	parameter int ANGLE_FRACTION_BITS = ANGLE_FRACTION_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [ANGLE_W-1:0]  angle,
	output q30_t                       sin_val,
	output q30_t                       cos_val
);

	localparam int LIM = 180 << ANGLE_FRACTION_BITS;
	localparam int QTR = 90 << ANGLE_FRACTION_BITS;
	localparam int RW  = $clog2(QTR);
	localparam int XPW = RW + 27;

	// stage 1: saturate, wrap into [0, 360), fold to quadrant
	int          a_c;
	int          r_c;
	logic [1:0]  quad_c;
	logic [RW-1:0] r_s1;
	logic [1:0]  quad_s1;

	always_comb begin
		a_c = int'(angle);
		if (a_c > LIM) a_c = LIM;
		if (a_c < -LIM) a_c = -LIM;
		if (a_c < 0) a_c = a_c + 2 * LIM;
		priority if (a_c >= 3 * QTR) quad_c = 2'd3;
		else if (a_c >= 2 * QTR) quad_c = 2'd2;
		else if (a_c >= QTR) quad_c = 2'd1;
		else quad_c = 2'd0;
		unique case (quad_c)
			2'd0: r_c = a_c;
			2'd1: r_c = a_c - QTR;
			2'd2: r_c = a_c - 2 * QTR;
			default: r_c = a_c - 3 * QTR;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1    <= r_c[RW-1:0];
			quad_s1 <= quad_c;
		end
	end

	// stage 2: radians in Q30
	logic [XPW-1:0] xprod;
	logic [30:0]    x_s2;
	logic [1:0]     quad_s2;
	assign xprod = XPW'(r_s1) * XPW'(DEG_TO_RAD_Q32);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2    <= 31'(xprod >> (ANGLE_FRACTION_BITS + 2));
			quad_s2 <= quad_s1;
		end
	end

	// stage 3: x squared, series start
	logic [61:0] sq;
	assign sq = 62'(x_s2) * 62'(x_s2);

	logic [31:0]        st_q   [0:7];
	logic [31:0]        ct_q   [0:7];
	logic signed [33:0] sacc_q [0:7];
	logic signed [33:0] cacc_q [0:7];
	logic [31:0]        x2_q   [0:7];
	logic [1:0]         qd_q   [0:7];

	always_ff @(posedge clk) begin
		if (en) begin
			st_q[0]   <= 32'(x_s2);
			sacc_q[0] <= 34'(x_s2);
			ct_q[0]   <= 32'(Q30_ONE);
			cacc_q[0] <= 34'(Q30_ONE);
			x2_q[0]   <= sq[61:30];
			qd_q[0]   <= quad_s2;
		end
	end

	// series terms: multiply by x^2, then exact divide via reciprocal
	logic [31:0]        sp_q    [1:7];
	logic [31:0]        cp_q    [1:7];
	logic signed [33:0] sacca_q [1:7];
	logic signed [33:0] cacca_q [1:7];
	logic [31:0]        x2a_q   [1:7];
	logic [1:0]         qda_q   [1:7];

	for (genvar k = 1; k <= 7; k++) begin : g_term
		localparam int SD = (2 * k) * (2 * k + 1);
		localparam int CD = (2 * k - 1) * (2 * k);
		localparam int SK = 32 + $clog2(SD);
		localparam int CK = 32 + $clog2(CD);
		localparam logic [32:0] SM = 33'(((65'd1 << SK) + 65'(SD) - 65'd1) / 65'(SD));
		localparam logic [32:0] CM = 33'(((65'd1 << CK) + 65'(CD) - 65'd1) / 65'(CD));

		logic [63:0] sprod;
		logic [63:0] cprod;
		logic [64:0] sdiv;
		logic [64:0] cdiv;
		logic [31:0] sq_t;
		logic [31:0] cq_t;

		assign sprod = 64'(st_q[k-1]) * 64'(x2_q[k-1]);
		assign cprod = 64'(ct_q[k-1]) * 64'(x2_q[k-1]);

		always_ff @(posedge clk) begin
			if (en) begin
				sp_q[k]    <= sprod[61:30];
				cp_q[k]    <= cprod[61:30];
				sacca_q[k] <= sacc_q[k-1];
				cacca_q[k] <= cacc_q[k-1];
				x2a_q[k]   <= x2_q[k-1];
				qda_q[k]   <= qd_q[k-1];
			end
		end

		assign sdiv = 65'(sp_q[k]) * 65'(SM);
		assign cdiv = 65'(cp_q[k]) * 65'(CM);
		assign sq_t = 32'(sdiv >> SK);
		assign cq_t = 32'(cdiv >> CK);

		always_ff @(posedge clk) begin
			if (en) begin
				st_q[k] <= sq_t;
				ct_q[k] <= cq_t;
				if (k % 2 == 1) begin
					sacc_q[k] <= sacca_q[k] - $signed(34'(sq_t));
					cacc_q[k] <= cacca_q[k] - $signed(34'(cq_t));
				end else begin
					sacc_q[k] <= sacca_q[k] + $signed(34'(sq_t));
					cacc_q[k] <= cacca_q[k] + $signed(34'(cq_t));
				end
				x2_q[k] <= x2a_q[k];
				qd_q[k] <= qda_q[k];
			end
		end
	end

	// final: clamp and unfold quadrant
	q30_t s_cl;
	q30_t c_cl;
	q30_t sin_s;
	q30_t cos_s;

	always_comb begin
		priority if (sacc_q[7] < 0) s_cl = '0;
		else if (sacc_q[7] > 34'(Q30_ONE)) s_cl = Q30_ONE;
		else s_cl = q30_t'(sacc_q[7]);
		priority if (cacc_q[7] < 0) c_cl = '0;
		else if (cacc_q[7] > 34'(Q30_ONE)) c_cl = Q30_ONE;
		else c_cl = q30_t'(cacc_q[7]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (qd_q[7])
				2'd0: begin sin_s <= s_cl;  cos_s <= c_cl;  end
				2'd1: begin sin_s <= c_cl;  cos_s <= -s_cl; end
				2'd2: begin sin_s <= -s_cl; cos_s <= -c_cl; end
				default: begin sin_s <= -c_cl; cos_s <= s_cl; end
			endcase
		end
	end

	assign sin_val = sin_s;
	assign cos_val = cos_s;

endmodule

[rtl/core/e2r_matmul.sv]
// ----------------------------------------------------------------------------
// e2r_matmul
// 3x3 Q30 matrix product, products registered, then sum and round.
// ----------------------------------------------------------------------------
module e2r_matmul import e2r_pkg::*; (
	input  logic clk,
	input  logic en,
	input  mat_t a,
	input  mat_t b,
	output mat_t m
);

	logic signed [PROD_W-1:0] prod_s1 [3][3][3];
	mat_t                     m_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					for (int k = 0; k < 3; k++)
						prod_s1[i][j][k] <= PROD_W'(a[i][k]) * PROD_W'(b[k][j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					m_s2[i][j] <= q30_t'(round_shift(SUM_W'(prod_s1[i][j][0])
						+ SUM_W'(prod_s1[i][j][1]) + SUM_W'(prod_s1[i][j][2]), 30));
		end
	end

	assign m = m_s2;

endmodule

[rtl/core/euler_angles_to_rotation_matrix.sv]
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix
// Roll/pitch/yaw in fixed-point degrees to a 3x3 Q1.14 rotation matrix.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: in_valid/in_ready with roll_angle, pitch_angle, yaw_angle
//    (signed, 1/128 degree by default, limited to +-180 degrees).
//  - Result channel: out_valid/out_ready with the nine entries (row by row)
//    and order_error.
//  - cfg_wr_en/cfg_wr_data write rotation_order: 0 = Rx*Ry*Rz with yaw on x,
//    1 = Rz*Ry*Rx with roll on x; other codes flag order_error with zero
//    entries. Write only while the block is empty.
//  - Throughput: one request per cycle while the skid entry is free. Three
//    sine/cosine lanes (one per angle) run side by side; two registered
//    3x3 product stages merge them.
//  - Pipeline: 18 lane stages, four product stages, one output register.
//  - Stall: a two-entry output buffer (output register plus skid) keeps the
//    pipeline moving while a result waits; in_ready drops only once the skid
//    entry is occupied, and the whole pipeline then holds.
//  - Reset: arst_n clears all valid flags and sets rotation_order to 3.
// ----------------------------------------------------------------------------
module euler_angles_to_rotation_matrix import e2r_pkg::*; #(
	parameter int ANGLE_FRACTION_BITS = ANGLE_FRACTION_BITS_DEF,
	parameter int ENTRY_FRACTION_BITS = ENTRY_FRACTION_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [1:0]                 cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [ANGLE_W-1:0]  roll_angle,
	input  logic signed [ANGLE_W-1:0]  pitch_angle,
	input  logic signed [ANGLE_W-1:0]  yaw_angle,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [ENTRY_W-1:0]  entry_r0c0,
	output logic signed [ENTRY_W-1:0]  entry_r0c1,
	output logic signed [ENTRY_W-1:0]  entry_r0c2,
	output logic signed [ENTRY_W-1:0]  entry_r1c0,
	output logic signed [ENTRY_W-1:0]  entry_r1c1,
	output logic signed [ENTRY_W-1:0]  entry_r1c2,
	output logic signed [ENTRY_W-1:0]  entry_r2c0,
	output logic signed [ENTRY_W-1:0]  entry_r2c1,
	output logic signed [ENTRY_W-1:0]  entry_r2c2,
	output logic                       order_error
);

	localparam int RND = 30 - ENTRY_FRACTION_BITS;

	logic [1:0] order_q;
	logic       en;
	logic [PIPE_DEPTH-1:0] vld_q;
	logic       out_vld_q;
	logic       skid_vld_q;
	res_t       out_q;
	res_t       skid_q;
	res_t       res_c;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_RESET;
		end else if (cfg_wr_en) begin
			order_q <= cfg_wr_data;
		end
	end

	// pipeline advances unless the skid entry holds a result
	assign en       = !skid_vld_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid};
		end
	end

	// axis mapping: order XYZ puts yaw on x, ZYX puts roll on x
	logic signed [ANGLE_W-1:0] ang_x;
	logic signed [ANGLE_W-1:0] ang_z;
	assign ang_x = (order_q == ORD_XYZ) ? yaw_angle : roll_angle;
	assign ang_z = (order_q == ORD_XYZ) ? roll_angle : yaw_angle;

	q30_t sx, cx, sy, cy, sz, cz;

	e2r_sincos #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_lane_x (
		.clk(clk), .en(en), .angle(ang_x), .sin_val(sx), .cos_val(cx));
	e2r_sincos #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_lane_y (
		.clk(clk), .en(en), .angle(pitch_angle), .sin_val(sy), .cos_val(cy));
	e2r_sincos #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_lane_z (
		.clk(clk), .en(en), .angle(ang_z), .sin_val(sz), .cos_val(cz));

	// first product
	mat_t ma, mb, mp, mc, mr;
	assign ma = (order_q == ORD_XYZ) ? rot_x(sx, cx) : rot_z(sz, cz);
	assign mb = rot_y(sy, cy);

	e2r_matmul u_mm1 (.clk(clk), .en(en), .a(ma), .b(mb), .m(mp));

	// third rotation waits out the first product
	q30_t sx_d [MM_DEPTH];
	q30_t cx_d [MM_DEPTH];
	q30_t sz_d [MM_DEPTH];
	q30_t cz_d [MM_DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			sx_d[0] <= sx; cx_d[0] <= cx; sz_d[0] <= sz; cz_d[0] <= cz;
			for (int i = 1; i < MM_DEPTH; i++) begin
				sx_d[i] <= sx_d[i-1]; cx_d[i] <= cx_d[i-1];
				sz_d[i] <= sz_d[i-1]; cz_d[i] <= cz_d[i-1];
			end
		end
	end

	assign mc = (order_q == ORD_XYZ) ? rot_z(sz_d[MM_DEPTH-1], cz_d[MM_DEPTH-1])
		: rot_x(sx_d[MM_DEPTH-1], cx_d[MM_DEPTH-1]);

	e2r_matmul u_mm2 (.clk(clk), .en(en), .a(mp), .b(mc), .m(mr));

	// output rounding and saturation
	logic signed [ENTRY_W-1:0] ent [3][3];
	logic signed [SUM_W-1:0]   rv;
	logic                      bad;

	always_comb begin
		bad = (order_q != ORD_XYZ) && (order_q != ORD_ZYX);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				rv = round_shift(SUM_W'(mr[i][j]), RND);
				if (rv > (SUM_W'(1) <<< ENTRY_FRACTION_BITS))
					rv = SUM_W'(1) <<< ENTRY_FRACTION_BITS;
				if (rv < -(SUM_W'(1) <<< ENTRY_FRACTION_BITS))
					rv = -(SUM_W'(1) <<< ENTRY_FRACTION_BITS);
				ent[i][j] = bad ? '0 : rv[ENTRY_W-1:0];
			end
		res_c.e00 = ent[0][0]; res_c.e01 = ent[0][1]; res_c.e02 = ent[0][2];
		res_c.e10 = ent[1][0]; res_c.e11 = ent[1][1]; res_c.e12 = ent[1][2];
		res_c.e20 = ent[2][0]; res_c.e21 = ent[2][1]; res_c.e22 = ent[2][2];
		res_c.err = bad;
	end

	// output register plus skid entry
	logic push;
	assign push = en && vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			priority if (skid_vld_q) begin
				if (out_ready) begin
					skid_vld_q <= 1'b0;
				end
			end else if (push) begin
				if (!out_vld_q || out_ready) begin
					out_vld_q <= 1'b1;
				end else begin
					skid_vld_q <= 1'b1;
				end
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_ready) out_q <= skid_q;
		end else if (push) begin
			if (!out_vld_q || out_ready) out_q <= res_c;
			else skid_q <= res_c;
		end
	end

	assign out_valid   = out_vld_q;
	assign entry_r0c0  = out_q.e00;
	assign entry_r0c1  = out_q.e01;
	assign entry_r0c2  = out_q.e02;
	assign entry_r1c0  = out_q.e10;
	assign entry_r1c1  = out_q.e11;
	assign entry_r1c2  = out_q.e12;
	assign entry_r2c0  = out_q.e20;
	assign entry_r2c1  = out_q.e21;
	assign entry_r2c2  = out_q.e22;
	assign order_error = out_q.err;

	// skid entry only ever holds a result behind a waiting output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry occupied with empty output register");

	// skid fills only when the output was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !out_ready))
		else $error("skid filled without an output stall");

	// unknown order gives zero entries (checked on five of the nine)
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.err) |-> (out_q.e00 == 0 && out_q.e11 == 0
			&& out_q.e22 == 0 && out_q.e01 == 0 && out_q.e20 == 0))
		else $error("order error with nonzero entries");

endmodule

[tb/euler_angles_to_rotation_matrix_test.sv]
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix_test
// Self-checking bench: angle triples go in over a valid/ready channel, each
// result is compared per entry with a fixed-point predictor or typed-in matrix.
// Covers every rotation order code, angle extremes, saturation beyond 180
// degrees, random bursts/stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module euler_angles_to_rotation_matrix_test import e2r_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int AFB = ANGLE_FRACTION_BITS_DEF;
	localparam int EFB = ENTRY_FRACTION_BITS_DEF;
	localparam int N_RANDOM = 1880;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [1:0] ORD_BAD2 = 2'd2;
	localparam logic [1:0] ORD_BAD3 = 2'd3;
	localparam logic signed [15:0] DEG180 = 16'sd23040;
	localparam logic signed [15:0] DEG90 = 16'sd11520;

	typedef longint m3_t [3][3];

	// one row of the directed table; has_exp marks rows with a typed-in matrix
	typedef struct {
		logic [1:0] order;
		logic signed [15:0] roll, pitch, yaw;
		bit has_exp;
		res_t exp_mat;
	} pose_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] roll_angle = '0, pitch_angle = '0, yaw_angle = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] entry_r0c0, entry_r0c1, entry_r0c2, entry_r1c0, entry_r1c1;
	logic signed [15:0] entry_r1c2, entry_r2c0, entry_r2c1, entry_r2c2;
	logic order_error;

	euler_angles_to_rotation_matrix dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
		.out_valid(out_valid), .out_ready(out_ready),
		.entry_r0c0(entry_r0c0), .entry_r0c1(entry_r0c1), .entry_r0c2(entry_r0c2),
		.entry_r1c0(entry_r1c0), .entry_r1c1(entry_r1c1), .entry_r1c2(entry_r1c2),
		.entry_r2c0(entry_r2c0), .entry_r2c1(entry_r2c1), .entry_r2c2(entry_r2c2),
		.order_error(order_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	res_t matrix_queue[$];   // expected matrices, oldest first
	logic [1:0] order_reg;   // bench copy of rotation_order
	int error_count = 0;
	int requests_sent = 0;
	int results_seen = 0;
	int orders_used[4];
	longint cycle_count = 0;
	bit long_hold = 1'b0;
	bit hold_done = 1'b0;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic longint round_half_away(longint v, int n);
		longint half;
		half = longint'(1) << (n - 1);
		if (v >= 0)
			return (v + half) >>> n;
		return -((-v + half) >>> n);
	endfunction

	// signed Q30 sine/cosine of an angle in 1/128 degree
	function automatic void angle_to_sin_cos(input longint ang, output longint sn,
		output longint cs);
		longint lim, quarter, r, s, c;
		longint unsigned x, x2, t;
		int quad;
		lim = longint'(180) << AFB;
		quarter = longint'(90) << AFB;
		if (ang > lim) ang = lim;
		if (ang < -lim) ang = -lim;
		if (ang < 0) ang += 2 * lim;
		quad = int'(ang / quarter) & 3;
		r = ang - quad * quarter;
		x = (longint'(r) * 74961321) >> (AFB + 2);
		x2 = (x * x) >> 30;
		t = x;
		s = t;
		for (int k = 1; k <= 7; k++) begin
			t = ((t * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
			s += (k & 1) ? -longint'(t) : longint'(t);
		end
		t = longint'(1) << 30;
		c = t;
		for (int k = 1; k <= 7; k++) begin
			t = ((t * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
			c += (k & 1) ? -longint'(t) : longint'(t);
		end
		if (s < 0) s = 0;
		if (s > (longint'(1) << 30)) s = longint'(1) << 30;
		if (c < 0) c = 0;
		if (c > (longint'(1) << 30)) c = longint'(1) << 30;
		case (quad)
			0: begin sn = s; cs = c; end
			1: begin sn = c; cs = -s; end
			2: begin sn = -s; cs = -c; end
			default: begin sn = -c; cs = s; end
		endcase
	endfunction

	function automatic m3_t q30_product(m3_t a, m3_t b);
		m3_t m;
		longint acc;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++)
					acc += a[i][k] * b[k][j];
				m[i][j] = round_half_away(acc, 30);
			end
		return m;
	endfunction

	function automatic res_t predict_matrix(logic [1:0] ord, logic signed [15:0] roll,
		logic signed [15:0] pitch, logic signed [15:0] yaw);
		res_t res;
		longint sx, cx, sy, cy, sz, cz, v, top, one;
		m3_t rx, ry, rz, p, m;
		logic [15:0] e[9];
		res = '0;
		if (ord != ORD_XYZ && ord != ORD_ZYX) begin
			res.err = 1'b1;
			return res;
		end
		one = longint'(1) << 30;
		top = longint'(1) << EFB;
		angle_to_sin_cos(ord == ORD_XYZ ? yaw : roll, sx, cx);
		angle_to_sin_cos(pitch, sy, cy);
		angle_to_sin_cos(ord == ORD_XYZ ? roll : yaw, sz, cz);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				rx[i][j] = (i == j) ? one : 0;
				ry[i][j] = rx[i][j];
				rz[i][j] = rx[i][j];
			end
		rx[1][1] = cx; rx[1][2] = -sx; rx[2][1] = sx; rx[2][2] = cx;
		ry[0][0] = cy; ry[0][2] = sy; ry[2][0] = -sy; ry[2][2] = cy;
		rz[0][0] = cz; rz[0][1] = -sz; rz[1][0] = sz; rz[1][1] = cz;
		if (ord == ORD_XYZ) begin
			p = q30_product(rx, ry);
			m = q30_product(p, rz);
		end else begin
			p = q30_product(rz, ry);
			m = q30_product(p, rx);
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				v = round_half_away(m[i][j], 30 - EFB);
				if (v > top) v = top;
				if (v < -top) v = -top;
				e[i * 3 + j] = v[15:0];
			end
		res = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8], 1'b0};
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Result checker: sampled at the edge, before NBA updates land
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {entry_r0c0, entry_r0c1, entry_r0c2, entry_r1c0, entry_r1c1,
				entry_r1c2, entry_r2c0, entry_r2c1, entry_r2c2, order_error};
			results_seen++;
			if (matrix_queue.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				error_count++;
			end else begin
				want = matrix_queue.pop_front();
				for (int f = 0; f < 9; f++)
					if (got[16 * (8 - f) + 1 +: 16] !== want[16 * (8 - f) + 1 +: 16]) begin
						$display("%0t: entry r%0dc%0d expected %0d actual %0d", $time,
							f / 3, f % 3, $signed(want[16 * (8 - f) + 1 +: 16]),
							$signed(got[16 * (8 - f) + 1 +: 16]));
						error_count++;
					end
				if (got.err !== want.err) begin
					$display("%0t: order_error expected %b actual %b", $time,
						want.err, got.err);
					error_count++;
				end
			end
		end
	end

	// receiver: own stall pattern, plus one long hold-off counted here
	always @(posedge clk) begin
		int hold_left;
		if (long_hold && !hold_done) begin
			out_ready <= 1'b0;
			hold_left = 300;
			hold_done = 1'b1;
			while (hold_left > 0) begin
				@(posedge clk);
				hold_left--;
			end
			long_hold = 1'b0;
		end
		case (($urandom >> 4) % 4)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 2) == 0);
			default: out_ready <= (cycle_count[6:4] != 3'd5);
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("euler_angles_to_rotation_matrix_test: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sender helpers
	// ------------------------------------------------------------------
	int burst_left = 0;

	// one request; waits for acceptance, then maybe a random gap
	task automatic send_pose(logic signed [15:0] r, logic signed [15:0] p,
		logic signed [15:0] y);
		int gap;
		roll_angle <= r;
		pitch_angle <= p;
		yaw_angle <= y;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		matrix_queue.push_back(predict_matrix(order_reg, r, p, y));
		requests_sent++;
		orders_used[order_reg]++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// drain, settle, then write rotation_order while idle
	task automatic set_order(logic [1:0] ord);
		in_valid <= 1'b0;
		@(posedge clk);
		while (matrix_queue.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= ord;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		order_reg = ord;
	endtask

	function automatic logic signed [15:0] random_angle();
		case ($urandom_range(0, 9))
			0: return 16'($urandom);                  // full 16-bit range
			1: return $urandom_range(0, 2) ? DEG180 : -DEG180;
			2: return 16'(($urandom_range(0, 8) - 4) * DEG90 / 2 + $urandom_range(0, 2) - 1);
			default: return 16'($signed($urandom_range(0, 46080)) - 23040);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------
	pose_row_t pose_table[] = '{
		// after reset the order code is unknown: zero matrix, error set
		'{ORDER_RESET, 16'sd0, 16'sd0, 16'sd0, 1'b1, res_t'(145'd1)},
		'{ORDER_RESET, DEG180, -DEG180, 16'sh7fff, 1'b1, res_t'(145'd1)},
		'{ORD_XYZ, 16'sd0, 16'sd0, 16'sd0, 1'b1,
			'{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0,
			16'sd0, 16'sd16384, 1'b0}},
		'{ORD_XYZ, DEG90, 16'sd0, 16'sd0, 1'b0, '0},
		'{ORD_XYZ, 16'sd0, DEG90, 16'sd0, 1'b0, '0},
		'{ORD_XYZ, 16'sd0, 16'sd0, DEG90, 1'b0, '0},
		'{ORD_XYZ, DEG180, -DEG180, DEG180, 1'b0, '0},
		'{ORD_XYZ, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0, '0},   // beyond 180: clamp
		'{ORD_XYZ, -16'sd1, 16'sd1, 16'sd5760, 1'b0, '0},
		'{ORD_ZYX, 16'sd0, 16'sd0, 16'sd0, 1'b1,
			'{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0,
			16'sd0, 16'sd16384, 1'b0}},
		'{ORD_ZYX, DEG90, -DEG90, DEG90, 1'b0, '0},
		'{ORD_ZYX, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, '0},
		'{ORD_ZYX, 16'sd3000, -16'sd17000, 16'sd22000, 1'b0, '0},
		'{ORD_ZYX, 16'sd11519, 16'sd11521, -16'sd23039, 1'b0, '0},
		'{ORD_BAD2, 16'sd1234, -16'sd4321, 16'sd99, 1'b1, res_t'(145'd1)},
		'{ORD_BAD3, DEG90, DEG90, DEG90, 1'b1, res_t'(145'd1)}
	};

	initial begin
		logic [1:0] ord;
		int phase_len;
		order_reg = ORDER_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (pose_table[i]) begin
			if (pose_table[i].order != order_reg)
				set_order(pose_table[i].order);
			send_pose(pose_table[i].roll, pose_table[i].pitch, pose_table[i].yaw);
			// swap in the typed-in matrix where the row carries one
			if (pose_table[i].has_exp) begin
				void'(matrix_queue.pop_back());
				matrix_queue.push_back(pose_table[i].exp_mat);
			end
		end

		// random phases, known orders dominate
		for (int n = 0; n < N_RANDOM; ) begin
			ord = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(2, 3))
				: 2'($urandom_range(0, 1));
			set_order(ord);
			phase_len = $urandom_range(80, 250);
			for (int k = 0; k < phase_len && n < N_RANDOM; k++, n++) begin
				if (n == 600)
					long_hold = 1'b1;   // sender keeps offering while output blocks
				send_pose(random_angle(), random_angle(), random_angle());
			end
		end
		set_order(ORD_XYZ);   // leaves the bench idle with all results back

		$display("%0d requests, %0d results; order 0/1/2/3 used %0d/%0d/%0d/%0d times",
			requests_sent, results_seen, orders_used[0], orders_used[1],
			orders_used[2], orders_used[3]);
		if (error_count == 0)
			$display("euler_angles_to_rotation_matrix_test: done, clean");
		else
			$display("euler_angles_to_rotation_matrix_test: done, errors");
		$finish;
	end

endmodule
